### rtl/core/fscl_pkg.sv
// ----------------------------------------------------------------------------
// Frame scaler package
// Shared constants, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package fscl_pkg;

  localparam int SRC_WIDTH_DEF  = 160;
  localparam int SRC_HEIGHT_DEF = 160;
  localparam int SCREEN_WIDTH   = 320;
  localparam int SCREEN_HEIGHT  = 240;
  localparam int SQUARE_SIDE    = 240;

  localparam int FRAC_W    = 16;
  localparam int ADDR_W    = 15;
  localparam int PIX_IN_W  = 15;
  localparam int PIX_OUT_W = 16;
  localparam int COL_W     = 9;
  localparam int ROW_W     = 8;
  localparam int IDX_W     = 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } fscl_op_e;

  typedef enum logic [1:0] {
    MODE_NATIVE  = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_SQUARE  = 2'd2
  } fscl_mode_e;

  typedef struct packed {
    logic                 is_load;
    logic [ADDR_W-1:0]    addr;
    logic [PIX_IN_W-1:0]  pixel;
    logic [COL_W-1:0]     src_x;
    logic [ROW_W-1:0]     src_y;
    logic [COL_W-1:0]     screen_x;
    logic [ROW_W-1:0]     screen_y;
    logic                 last;
  } fscl_cmd_t;

endpackage

### rtl/core/fscl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module fscl_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fscl_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of command words between the front and the back.
// ----------------------------------------------------------------------------
module fscl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fscl_pkg::fscl_cmd_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output fscl_pkg::fscl_cmd_t rdata_o,
  output logic              empty_o
);

  import fscl_pkg::*;

  fscl_cmd_t               entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0]  count_q, count_d;
  logic                    do_push, do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/fscl_front.sv
// ----------------------------------------------------------------------------
// Scaler front end
// Holds the mode register, sorts words into loads and fetches, walks the
// drawn area and the 8.16 source accumulators, and issues command words.
// ----------------------------------------------------------------------------
module fscl_front #(
  parameter int SRC_WIDTH  = fscl_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = fscl_pkg::SRC_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          operation_i,
  input  logic [fscl_pkg::ADDR_W-1:0]   source_address_i,
  input  logic [fscl_pkg::PIX_IN_W-1:0] source_pixel_i,
  output logic                          cmd_push_o,
  output fscl_pkg::fscl_cmd_t           cmd_o
);

  import fscl_pkg::*;

  localparam int AXW = $clog2(SRC_WIDTH + 1) + FRAC_W;
  localparam int AYW = $clog2(SRC_HEIGHT + 1) + FRAC_W;
  localparam int XIW = AXW - FRAC_W;
  localparam int YIW = AYW - FRAC_W;

  localparam logic [31:0] STORE_SIZE = 32'(SRC_WIDTH * SRC_HEIGHT);

  localparam int IX_NAT = (SRC_WIDTH * 65536) / SRC_WIDTH;
  localparam int IY_NAT = (SRC_HEIGHT * 65536) / SRC_HEIGHT;
  localparam int IX_STR = (SRC_WIDTH * 65536) / SCREEN_WIDTH;
  localparam int IY_STR = (SRC_HEIGHT * 65536) / SCREEN_HEIGHT;
  localparam int IX_SQR = (SRC_WIDTH * 65536) / SQUARE_SIDE;
  localparam int IY_SQR = (SRC_HEIGHT * 65536) / SQUARE_SIDE;
  localparam int OX_NAT = (SCREEN_WIDTH - SRC_WIDTH) / 2;
  localparam int OY_NAT = (SCREEN_HEIGHT - SRC_HEIGHT) / 2;
  localparam int OX_SQR = (SCREEN_WIDTH - SQUARE_SIDE) / 2;
  localparam int OY_SQR = (SCREEN_HEIGHT - SQUARE_SIDE) / 2;

  logic [1:0]       scale_mode_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [AXW-1:0]   accx_q, accx_d;
  logic [AYW-1:0]   accy_q, accy_d;

  logic             mode_ok;
  logic [COL_W-1:0] area_w, ox;
  logic [ROW_W-1:0] area_h, oy;
  logic [AXW-1:0]   step_x;
  logic [AYW-1:0]   step_y;

  logic             restart, is_fetch, load_ok, fetch_go;
  logic [COL_W-1:0] col, col_n;
  logic [ROW_W-1:0] row, row_n;
  logic [AXW-1:0]   accx;
  logic [AYW-1:0]   accy;
  logic [XIW-1:0]   sx;
  logic [YIW-1:0]   sy;

  always_comb begin
    mode_ok = 1'b1;
    area_w  = COL_W'(SRC_WIDTH);
    area_h  = ROW_W'(SRC_HEIGHT);
    ox      = COL_W'(OX_NAT);
    oy      = ROW_W'(OY_NAT);
    step_x  = AXW'(IX_NAT);
    step_y  = AYW'(IY_NAT);
    unique case (scale_mode_q)
      MODE_NATIVE: begin
        mode_ok = 1'b1;
      end
      MODE_STRETCH: begin
        area_w = COL_W'(SCREEN_WIDTH);
        area_h = ROW_W'(SCREEN_HEIGHT);
        ox     = '0;
        oy     = '0;
        step_x = AXW'(IX_STR);
        step_y = AYW'(IY_STR);
      end
      MODE_SQUARE: begin
        area_w = COL_W'(SQUARE_SIDE);
        area_h = ROW_W'(SQUARE_SIDE);
        ox     = COL_W'(OX_SQR);
        oy     = ROW_W'(OY_SQR);
        step_x = AXW'(IX_SQR);
        step_y = AYW'(IY_SQR);
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    is_fetch = (operation_i == OP_FETCH);
    load_ok  = !is_fetch && (32'(source_address_i) < STORE_SIZE);
    fetch_go = in_valid_i && is_fetch && mode_ok;

    restart = (col_q >= area_w) || (row_q >= area_h);
    col     = restart ? '0 : col_q;
    row     = restart ? '0 : row_q;
    accx    = restart ? '0 : accx_q;
    accy    = restart ? '0 : accy_q;

    sx = accx[AXW-1:FRAC_W];
    sy = accy[AYW-1:FRAC_W];
    if (sx > XIW'(SRC_WIDTH - 1)) begin
      sx = XIW'(SRC_WIDTH - 1);
    end
    if (sy > YIW'(SRC_HEIGHT - 1)) begin
      sy = YIW'(SRC_HEIGHT - 1);
    end

    cmd_o.is_load  = !is_fetch;
    cmd_o.addr     = source_address_i;
    cmd_o.pixel    = source_pixel_i;
    cmd_o.src_x    = COL_W'(sx);
    cmd_o.src_y    = ROW_W'(sy);
    cmd_o.screen_x = ox + col;
    cmd_o.screen_y = oy + row;
    cmd_o.last     = (col == area_w - 1'b1) && (row == area_h - 1'b1);

    cmd_push_o = in_valid_i && (load_ok || (is_fetch && mode_ok));

    col_n  = col + 1'b1;
    row_n  = row;
    col_d  = col_n;
    row_d  = row;
    accx_d = accx + step_x;
    accy_d = accy;
    if (col_n >= area_w) begin
      col_d  = '0;
      accx_d = '0;
      row_n  = row + 1'b1;
      row_d  = row_n;
      accy_d = accy + step_y;
      if (row_n >= area_h) begin
        row_d  = '0;
        accy_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mode_q <= MODE_NATIVE;
      col_q        <= '0;
      row_q        <= '0;
      accx_q       <= '0;
      accy_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_mode_q <= cfg_wdata_i;
      end
      if (fetch_go) begin
        col_q  <= col_d;
        row_q  <= row_d;
        accx_q <= accx_d;
        accy_q <= accy_d;
      end
    end
  end

endmodule

### rtl/core/fscl_back.sv
// ----------------------------------------------------------------------------
// Scaler back end
// Executes command words against the frame store: loads write, fetches read
// one pixel, convert it to RGB565 and present it in the result register.
// ----------------------------------------------------------------------------
module fscl_back #(
  parameter int SRC_WIDTH  = fscl_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = fscl_pkg::SRC_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fscl_pkg::fscl_cmd_t            cmd_i,
  input  logic                           cmd_empty_i,
  output logic                           cmd_pop_o,
  output logic [fscl_pkg::PIX_OUT_W-1:0] pixel_value_o,
  output logic [fscl_pkg::COL_W-1:0]     screen_x_o,
  output logic [fscl_pkg::ROW_W-1:0]     screen_y_o,
  output logic                           frame_last_o,
  output logic                           empty,
  input  logic                           pop
);

  import fscl_pkg::*;

  localparam int MEM_DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  logic                  ram_we, ram_re;
  logic [MEM_AW-1:0]     ram_waddr, ram_raddr;
  logic [PIX_IN_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]      idx;

  logic                  rd_valid_q;
  logic [COL_W-1:0]      rd_x_q;
  logic [ROW_W-1:0]      rd_y_q;
  logic                  rd_last_q;

  logic                  out_valid_q;
  logic [PIX_OUT_W-1:0]  out_pixel_q;
  logic [COL_W-1:0]      out_x_q;
  logic [ROW_W-1:0]      out_y_q;
  logic                  out_last_q;

  logic                  out_pop, slot_free, rd_adv, can_issue, issue;

  assign out_pop   = pop && out_valid_q;
  assign slot_free = !out_valid_q || out_pop;
  assign rd_adv    = rd_valid_q && slot_free;
  assign can_issue = !rd_valid_q || rd_adv;
  assign issue     = !cmd_empty_i && !cmd_i.is_load && can_issue;
  assign cmd_pop_o = !cmd_empty_i && (cmd_i.is_load || can_issue);

  assign idx       = IDX_W'(cmd_i.src_y) * IDX_W'(SRC_WIDTH) + IDX_W'(cmd_i.src_x);
  assign ram_we    = !cmd_empty_i && cmd_i.is_load;
  assign ram_re    = issue;
  assign ram_waddr = MEM_AW'(cmd_i.addr);
  assign ram_raddr = MEM_AW'(idx);

  fscl_ram #(
    .WIDTH (PIX_IN_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.pixel),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (rd_adv) begin
        rd_valid_q <= 1'b0;
      end
      if (rd_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_x_q    <= cmd_i.screen_x;
      rd_y_q    <= cmd_i.screen_y;
      rd_last_q <= cmd_i.last;
    end
    if (rd_adv) begin
      out_pixel_q <= {ram_rdata[14:5], 1'b0, ram_rdata[4:0]};
      out_x_q     <= rd_x_q;
      out_y_q     <= rd_y_q;
      out_last_q  <= rd_last_q;
    end
  end

  assign empty         = !out_valid_q;
  assign pixel_value_o = out_pixel_q;
  assign screen_x_o    = out_x_q;
  assign screen_y_o    = out_y_q;
  assign frame_last_o  = out_last_q;

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("store write and read issued together");

  a_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> rd_valid_q)
    else $error("issued read lost");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !slot_free) |=> (rd_valid_q && $stable(ram_rdata) && $stable(rd_x_q)
                                    && $stable(rd_y_q) && $stable(rd_last_q)))
    else $error("stalled read stage changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(out_pixel_q)))
    else $error("waiting result changed");

endmodule

### rtl/core/frame_scaler_rgb555_to_rgb565.sv
// ----------------------------------------------------------------------------
// Frame scaler, RGB555 source to RGB565 screen
// Nearest-neighbor scaler from a stored source frame onto a 320x240 screen.
// ----------------------------------------------------------------------------
// Load words write one RGB555 pixel into the frame store; fetch words return
// the next RGB565 pixel of the drawn area in raster order with its screen
// position and an end-of-frame flag. Both kinds sustain one word per clock
// while the queue has room and results are popped; a fetch result goes through
// the four-entry command queue, the store read register and the result
// register, so input and output stall independently. Read a store entry only
// after loading it. Change the scale mode only while no word is in flight.
module frame_scaler_rgb555_to_rgb565 #(
  parameter int SRC_WIDTH  = fscl_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = fscl_pkg::SRC_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           operation_i,
  input  logic [fscl_pkg::ADDR_W-1:0]    source_address_i,
  input  logic [fscl_pkg::PIX_IN_W-1:0]  source_pixel_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [fscl_pkg::PIX_OUT_W-1:0] pixel_value_o,
  output logic [fscl_pkg::COL_W-1:0]     screen_x_o,
  output logic [fscl_pkg::ROW_W-1:0]     screen_y_o,
  output logic                           frame_last_o
);

  import fscl_pkg::*;

  logic      in_valid;
  logic      cmd_push, q_full, q_pop, q_empty;
  fscl_cmd_t cmd_in, q_head;

  assign in_valid = push && !q_full;
  assign full     = q_full;

  fscl_front #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid),
    .operation_i      (operation_i),
    .source_address_i (source_address_i),
    .source_pixel_i   (source_pixel_i),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in)
  );

  fscl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  fscl_back #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (q_head),
    .cmd_empty_i   (q_empty),
    .cmd_pop_o     (q_pop),
    .pixel_value_o (pixel_value_o),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .frame_last_o  (frame_last_o),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

### verif/tb_frame_scaler_rgb555_to_rgb565.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame scaler testbench
// Drives load and fetch words into the scaler and checks every returned
// pixel against an in-bench nearest-neighbor model of the three scale modes.
// A short table covers the color extremes, ignored addresses, the undefined
// mode and mode changes mid-frame. Random phases at every mode follow, with
// bursts of idling on both sides and one long output stall. A short native
// run without idling closes the test.
// ----------------------------------------------------------------------------
module tb_frame_scaler_rgb555_to_rgb565;
  import fscl_pkg::*;

  localparam int SRC_W          = SRC_WIDTH_DEF;
  localparam int SRC_H          = SRC_HEIGHT_DEF;
  localparam int FRAME_WORDS    = SRC_W * SRC_H;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int SWEEP_FETCHES  = 60;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int PHASES         = 8;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  localparam logic [1:0] PHASE_MODE [PHASES] = '{
    MODE_STRETCH, MODE_STRETCH, MODE_NATIVE, MODE_SQUARE,
    MODE_UNDEF, MODE_SQUARE, MODE_STRETCH, MODE_NATIVE
  };
  localparam int PHASE_ITEMS [PHASES] = '{160, 140, 170, 170, 10, 170, 160, 170};
  localparam bit PHASE_IDLE  [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};

  typedef struct packed {
    logic [PIX_OUT_W-1:0] pixel;
    logic [COL_W-1:0]     x;
    logic [ROW_W-1:0]     y;
    logic                 last;
  } screen_word_t;

  typedef struct packed {
    logic       ok;
    logic [8:0] w;
    logic [8:0] h;
    logic [8:0] ox;
    logic [7:0] oy;
  } area_t;

  typedef enum logic [1:0] {STEP_LOAD, STEP_FETCH, STEP_MODE} step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    logic [ADDR_W-1:0]   addr;
    logic [PIX_IN_W-1:0] pixel;
    logic [1:0]          mode;
    logic                typed;
    screen_word_t        want;
  } step_t;

  localparam screen_word_t NO_WANT = '0;

  localparam step_t DIRECTED_STEPS [22] = '{
    '{STEP_LOAD,  15'd0,     15'h7FFF, 2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'h7FFF,  15'h7FFF, 2'd0, 1'b1, '{16'hFFDF, 9'd80, 8'd40, 1'b0}},
    '{STEP_LOAD,  15'd1,     15'h0000, 2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'd0,     15'd0,    2'd0, 1'b1, '{16'h0000, 9'd81, 8'd40, 1'b0}},
    '{STEP_LOAD,  15'd2,     15'h001F, 2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'h5555,  15'h2AAA, 2'd0, 1'b1, '{16'h001F, 9'd82, 8'd40, 1'b0}},
    '{STEP_LOAD,  15'd3,     15'h7FE0, 2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'h2AAA,  15'h5555, 2'd0, 1'b1, '{16'hFFC0, 9'd83, 8'd40, 1'b0}},
    '{STEP_LOAD,  15'd25599, 15'h5555, 2'd0, 1'b0, NO_WANT},
    '{STEP_LOAD,  15'd25600, 15'h1234, 2'd0, 1'b0, NO_WANT},
    '{STEP_LOAD,  15'd32767, 15'h7FFF, 2'd0, 1'b0, NO_WANT},
    '{STEP_MODE,  15'd0,     15'd0,    MODE_UNDEF, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'd0,     15'd0,    2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'h7FFF,  15'h7FFF, 2'd0, 1'b0, NO_WANT},
    '{STEP_MODE,  15'd0,     15'd0,    MODE_NATIVE, 1'b0, NO_WANT},
    '{STEP_LOAD,  15'd4,     15'h2AAA, 2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'd0,     15'd0,    2'd0, 1'b1, '{16'h554A, 9'd84, 8'd40, 1'b0}},
    '{STEP_MODE,  15'd0,     15'd0,    MODE_STRETCH, 1'b0, NO_WANT},
    '{STEP_LOAD,  15'd5,     15'h1234, 2'd0, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'd0,     15'd0,    2'd0, 1'b0, NO_WANT},
    '{STEP_MODE,  15'd0,     15'd0,    MODE_SQUARE, 1'b0, NO_WANT},
    '{STEP_FETCH, 15'd0,     15'd0,    2'd0, 1'b0, NO_WANT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic push;
  logic full;
  logic operation_i;
  logic [ADDR_W-1:0] source_address_i;
  logic [PIX_IN_W-1:0] source_pixel_i;
  logic empty;
  logic pop;
  logic [PIX_OUT_W-1:0] pixel_value_o;
  logic [COL_W-1:0] screen_x_o;
  logic [ROW_W-1:0] screen_y_o;
  logic frame_last_o;

  logic [PIX_IN_W-1:0] src_frame [FRAME_WORDS];
  bit                  src_loaded [FRAME_WORDS];
  int                  area_col;
  int                  area_row;
  logic [23:0]         acc_x;
  logic [23:0]         acc_y;
  logic [1:0]          scale_sel;

  screen_word_t pending_pixels [$];
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  hold_start = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;

  frame_scaler_rgb555_to_rgb565 DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .operation_i      (operation_i),
    .source_address_i (source_address_i),
    .source_pixel_i   (source_pixel_i),
    .empty            (empty),
    .pop              (pop),
    .pixel_value_o    (pixel_value_o),
    .screen_x_o       (screen_x_o),
    .screen_y_o       (screen_y_o),
    .frame_last_o     (frame_last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic area_t area_for(logic [1:0] m);
    area_t a;
    a = '0;
    a.ok = 1'b1;
    case (m)
      MODE_NATIVE: begin
        a.w  = 9'(SRC_W);
        a.h  = 9'(SRC_H);
        a.ox = 9'((SCREEN_WIDTH - SRC_W) / 2);
        a.oy = 8'((SCREEN_HEIGHT - SRC_H) / 2);
      end
      MODE_STRETCH: begin
        a.w = 9'(SCREEN_WIDTH);
        a.h = 9'(SCREEN_HEIGHT);
      end
      MODE_SQUARE: begin
        a.w  = 9'(SQUARE_SIDE);
        a.h  = 9'(SQUARE_SIDE);
        a.ox = 9'((SCREEN_WIDTH - SQUARE_SIDE) / 2);
        a.oy = 8'((SCREEN_HEIGHT - SQUARE_SIDE) / 2);
      end
      default: a.ok = 1'b0;
    endcase
    return a;
  endfunction

  function automatic int source_index(logic [23:0] ax, logic [23:0] ay);
    int sx;
    int sy;
    sx = int'(ax[23:16]);
    sy = int'(ay[23:16]);
    if (sx > SRC_W - 1) sx = SRC_W - 1;
    if (sy > SRC_H - 1) sy = SRC_H - 1;
    return sy * SRC_W + sx;
  endfunction

  // -1 when the mode draws nothing
  function automatic int next_fetch_index();
    area_t a;
    a = area_for(scale_sel);
    if (!a.ok) return -1;
    if (area_col >= int'(a.w) || area_row >= int'(a.h)) return 0;
    return source_index(acc_x, acc_y);
  endfunction

  task automatic predict_word(input fscl_op_e op, input logic [ADDR_W-1:0] addr,
                              input logic [PIX_IN_W-1:0] pix, output bit produced,
                              output screen_word_t res);
    area_t a;
    int idx;
    logic [PIX_IN_W-1:0] p;
    produced = 1'b0;
    res = '0;
    if (op == OP_LOAD) begin
      if (int'(addr) < FRAME_WORDS) begin
        src_frame[addr] = pix;
        src_loaded[addr] = 1'b1;
      end
      return;
    end
    a = area_for(scale_sel);
    if (!a.ok) return;
    if (area_col >= int'(a.w) || area_row >= int'(a.h)) begin
      area_col = 0;
      area_row = 0;
      acc_x = '0;
      acc_y = '0;
    end
    idx = source_index(acc_x, acc_y);
    p = src_frame[idx];
    produced = 1'b1;
    res.pixel = {p[14:5], 1'b0, p[4:0]};
    res.x = 9'(int'(a.ox) + area_col);
    res.y = 8'(int'(a.oy) + area_row);
    res.last = (area_col == int'(a.w) - 1) && (area_row == int'(a.h) - 1);
    area_col++;
    acc_x = acc_x + 24'((SRC_W << FRAC_W) / int'(a.w));
    if (area_col >= int'(a.w)) begin
      area_col = 0;
      acc_x = '0;
      area_row++;
      acc_y = acc_y + 24'((SRC_H << FRAC_W) / int'(a.h));
      if (area_row >= int'(a.h)) begin
        area_row = 0;
        acc_y = '0;
      end
    end
  endtask

  task automatic send_word(input fscl_op_e op, input logic [ADDR_W-1:0] addr,
                           input logic [PIX_IN_W-1:0] pix, input bit typed,
                           input screen_word_t want);
    bit produced;
    screen_word_t res;
    push <= 1'b1;
    operation_i <= op;
    source_address_i <= addr;
    source_pixel_i <= pix;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_word(op, addr, pix, produced, res);
    if (typed) pending_pixels.push_back(want);
    else if (produced) pending_pixels.push_back(res);
  endtask

  task automatic settle_block();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    settle_block();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale_sel = m;
  endtask

  // Load the entry the next fetch reads if it is still unwritten.
  task automatic random_word(input int fetch_pct, output bit counted, output bit fetched);
    int idx;
    logic [ADDR_W-1:0] addr;
    logic [PIX_IN_W-1:0] pix;
    idx = next_fetch_index();
    addr = ADDR_W'($urandom);
    pix = PIX_IN_W'($urandom);
    counted = 1'b1;
    fetched = 1'b0;
    if ($urandom_range(1, 100) <= fetch_pct) begin
      if (idx >= 0 && !src_loaded[idx]) begin
        send_word(OP_LOAD, ADDR_W'(idx), pix, 1'b0, NO_WANT);
      end else begin
        send_word(OP_FETCH, addr, pix, 1'b0, NO_WANT);
        fetched = 1'b1;
        counted = (idx >= 0);
      end
    end else begin
      if ($urandom_range(0, 9) == 0) addr = ADDR_W'($urandom_range(FRAME_WORDS, 32767));
      else addr = ADDR_W'($urandom_range(0, FRAME_WORDS - 1));
      counted = (int'(addr) < FRAME_WORDS);
      send_word(OP_LOAD, addr, pix, 1'b0, NO_WANT);
    end
  endtask

  task automatic check_screen_word();
    screen_word_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected word: pixel_value %h at %0d,%0d", pixel_value_o, screen_x_o,
             screen_y_o);
      mismatches++;
      return;
    end
    want = pending_pixels.pop_front();
    if (pixel_value_o !== want.pixel) begin
      $error("pixel_value: expected %h, got %h", want.pixel, pixel_value_o);
      mismatches++;
    end
    if (screen_x_o !== want.x) begin
      $error("screen_x: expected %0d, got %0d", want.x, screen_x_o);
      mismatches++;
    end
    if (screen_y_o !== want.y) begin
      $error("screen_y: expected %0d, got %0d", want.y, screen_y_o);
      mismatches++;
    end
    if (frame_last_o !== want.last) begin
      $error("frame_last: expected %b, got %b", want.last, frame_last_o);
      mismatches++;
    end
  endtask

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_screen_word();
      if (hold_start && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    bit counted;
    bit fetched;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    push <= 1'b0;
    operation_i <= OP_LOAD;
    source_address_i <= '0;
    source_pixel_i <= '0;
    area_col = 0;
    area_row = 0;
    acc_x = '0;
    acc_y = '0;
    scale_sel = MODE_NATIVE;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_STEPS[i]) begin
      case (DIRECTED_STEPS[i].kind)
        STEP_MODE: write_mode(DIRECTED_STEPS[i].mode);
        STEP_LOAD: send_word(OP_LOAD, DIRECTED_STEPS[i].addr, DIRECTED_STEPS[i].pixel,
                             1'b0, NO_WANT);
        default:   send_word(OP_FETCH, DIRECTED_STEPS[i].addr, DIRECTED_STEPS[i].pixel,
                             DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(PHASE_MODE[ph]);
      idle_on = PHASE_IDLE[ph];
      if (ph == 1) hold_start = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS[ph]) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk_i);
        end
        random_word(85, counted, fetched);
        n += counted;
      end
    end

    // finish in native mode with no idling
    write_mode(MODE_NATIVE);
    idle_on = 1'b0;
    n = 0;
    while (n < SWEEP_FETCHES) begin
      random_word(100, counted, fetched);
      n += fetched;
    end

    settle_block();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
